@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the orbit integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TBEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define TBEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/tbec_pkg.sv @@
// Constants and types of the two-body Euler-Cromer integrator.
`default_nettype none
package tbec_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int CFG_BITS  = 31;
  localparam int CFG_IDX_BITS = 8;
  localparam int IN_DATA_BITS  = 6 * WORD_BITS;
  localparam int OUT_DATA_BITS = 256;
  localparam int CNT_BITS = 7;
  localparam logic [CNT_BITS-1:0] LONG_STEPS = CNT_BITS'(64);
  localparam logic [CNT_BITS-1:0] ROOT_STEPS = CNT_BITS'(32);

  localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [CFG_BITS-1:0] GRAV_RESET = CFG_BITS'(662337939);
  localparam logic [CFG_BITS-1:0] STEP_RESET = CFG_BITS'(16777);

  localparam logic [CFG_IDX_BITS-1:0] CFG_GRAV = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP = CFG_IDX_BITS'(1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;
  localparam logic [1:0] STATUS_BAD  = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

endpackage
`default_nettype wire

@@ sv/two_body_euler_cromer_step.sv @@
// Top level of the bit-serial Euler-Cromer orbit integrator.
`default_nettype none
`include "assert_macros.svh"
// One body around a fixed central mass, signed Q8.24 state. A transaction with
// tuser low loads position and velocity; with tuser high it advances one time
// step: radius r from the current position, acceleration grav_param/r^2 toward
// the center, velocity updated first, then position from the new velocity. Every
// transaction returns one result: new state, pre-step radius, new speed, status
// (ok, zero radius, saturated). All arithmetic runs on one shared bit-serial
// unit that retires one quotient or multiplier bit per cycle or one root digit
// per cycle, with a setup state before each operation. The input is taken
// only while the sequencer is idle; the result sits in an output register, so
// the next transaction may enter while the last result still waits.
// grav_param and step_size are written on the cfg channel while idle.
module two_body_euler_cromer_step (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  wire  [tbec_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // command
  input  wire  [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // new_pos_x/y/z, new_vel_x/y/z, radius, speed, status
  output logic [tbec_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [tbec_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire  [tbec_pkg::WORD_BITS-1:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQP, S_ACCP, S_SQRTR, S_GETR, S_DIVG, S_GETMAG, S_MULA, S_DIVA,
    S_MULH, S_VUPD, S_MULP, S_PUPD, S_SQV, S_ACCV, S_SQRTS, S_GETS, S_DONE, S_RUN
  } state_e;

  typedef enum logic [1:0] {OP_MUL, OP_DIV, OP_SQRT} op_e;

  state_e state_q, next_q;
  op_e    op_q;
  logic [tbec_pkg::CNT_BITS-1:0] cnt_q;
  logic [127:0] acc_q;
  logic [63:0]  opd_q;
  logic         div_sat_q;

  tbec_pkg::word_t pos_q [3];
  tbec_pkg::word_t vel_q [3];
  logic [1:0]   idx_q;
  logic [63:0]  r2_q;
  logic [31:0]  r_q;
  logic [31:0]  spd_q;
  logic [63:0]  mag_q;
  logic         step_q, ovf_q, zr_q;
  logic         m_valid_q;
  logic [tbec_pkg::OUT_DATA_BITS-1:0] m_data_q;

  logic [tbec_pkg::CFG_BITS-1:0] grav_q, step_size_q;

  // Shared serial unit: one step per cycle.
  logic [64:0]  mul_sum, div_t, div_r;
  logic         div_ge, sq_ge;
  logic [35:0]  sq_t, sq_trial, sq_r;
  logic [127:0] run_acc;
  logic [63:0]  run_opd;
  logic [63:0]  quot, prod_sh;
  logic [32:0]  vupd, pupd;
  logic [31:0]  rad_c, spd_c, cur_mag;
  logic         fin_ovf;
  logic [1:0]   fin_status;

  function automatic logic [31:0] mag32(input logic [31:0] w);
    return w[31] ? (~w + 32'd1) : w;
  endfunction

  // base +/- amt clamped to the signed word; bit 32 flags a clamp.
  function automatic logic [32:0] sat_add(input logic [31:0] base,
                                          input logic [63:0] amt,
                                          input logic neg);
    logic [32:0] a33;
    logic signed [34:0] s;
    logic [32:0] res;
    a33 = (|amt[63:33] || (amt[32] && |amt[31:0])) ? {1'b1, 32'd0} : amt[32:0];
    if (neg) s = $signed({{3{base[31]}}, base}) - $signed({2'b00, a33});
    else     s = $signed({{3{base[31]}}, base}) + $signed({2'b00, a33});
    if (s > $signed({3'b000, tbec_pkg::SMAX}))      res = {1'b1, tbec_pkg::SMAX};
    else if (s < $signed({3'b111, tbec_pkg::SMIN})) res = {1'b1, tbec_pkg::SMIN};
    else                                            res = {1'b0, s[31:0]};
    return res;
  endfunction

  always_comb begin
    mul_sum  = {1'b0, acc_q[127:64]} + (acc_q[0] ? {1'b0, opd_q} : 65'd0);
    div_t    = {acc_q[127:64], acc_q[63]};
    div_ge   = div_t >= {1'b0, opd_q};
    div_r    = div_ge ? div_t - {1'b0, opd_q} : div_t;
    sq_t     = {acc_q[97:64], acc_q[63:62]};
    sq_trial = {2'b00, opd_q[31:0], 2'b01};
    sq_ge    = sq_t >= sq_trial;
    sq_r     = sq_ge ? sq_t - sq_trial : sq_t;
    case (op_q)
      OP_MUL: begin
        run_acc = {mul_sum, acc_q[63:1]};
        run_opd = opd_q;
      end
      OP_DIV: begin
        run_acc = {div_r[63:0], acc_q[62:0], div_ge};
        run_opd = opd_q;
      end
      OP_SQRT: begin
        run_acc = {30'd0, sq_r[33:0], acc_q[61:0], 2'b00};
        run_opd = {32'd0, opd_q[30:0], sq_ge};
      end
      default: begin
        run_acc = acc_q;
        run_opd = opd_q;
      end
    endcase
    quot    = div_sat_q ? {64{1'b1}} : acc_q[63:0];
    // floor(product / 2^FRAC_BITS), saturated
    prod_sh = (|acc_q[127:64+tbec_pkg::FRAC_BITS]) ? {64{1'b1}}
            : acc_q[64+tbec_pkg::FRAC_BITS-1:tbec_pkg::FRAC_BITS];
    vupd    = sat_add(vel_q[idx_q], prod_sh, !pos_q[idx_q][31]);
    pupd    = sat_add(pos_q[idx_q], prod_sh, vel_q[idx_q][31]);
    cur_mag = mag32(pos_q[idx_q]);
    rad_c   = r_q[31] ? tbec_pkg::SMAX : r_q;
    spd_c   = spd_q[31] ? tbec_pkg::SMAX : spd_q;
    fin_ovf = ovf_q | r_q[31] | spd_q[31];
    fin_status = fin_ovf ? tbec_pkg::STATUS_SAT
               : (zr_q ? tbec_pkg::STATUS_ZERO : tbec_pkg::STATUS_OK);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q      <= tbec_pkg::GRAV_RESET;
      step_size_q <= tbec_pkg::STEP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tbec_pkg::CFG_GRAV) grav_q <= cfg_data_i[tbec_pkg::CFG_BITS-1:0];
      if (cfg_index_i == tbec_pkg::CFG_STEP) begin
        step_size_q <= cfg_data_i[tbec_pkg::CFG_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_q    <= S_IDLE;
      op_q      <= OP_MUL;
      cnt_q     <= '0;
      acc_q     <= '0;
      opd_q     <= '0;
      div_sat_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
        vel_q[k] <= '0;
      end
      idx_q     <= '0;
      r2_q      <= '0;
      r_q       <= '0;
      spd_q     <= '0;
      mag_q     <= '0;
      step_q    <= 1'b0;
      ovf_q     <= 1'b0;
      zr_q      <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // drop the result once taken; in S_DONE a new one replaces it below
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            step_q <= (s_axis_tuser[0] == tbec_pkg::CMD_STEP);
            if (s_axis_tuser[0] == tbec_pkg::CMD_LOAD) begin
              for (int k = 0; k < 3; k++) begin
                pos_q[k] <= s_axis_tdata[32*k +: 32];
                vel_q[k] <= s_axis_tdata[32*(k+3) +: 32];
              end
            end
            idx_q   <= '0;
            r2_q    <= '0;
            ovf_q   <= 1'b0;
            zr_q    <= 1'b0;
            state_q <= S_SQP;
          end
        end
        S_RUN: begin
          acc_q <= run_acc;
          opd_q <= run_opd;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == tbec_pkg::CNT_BITS'(1)) state_q <= next_q;
        end
        S_SQP: begin
          acc_q   <= {96'd0, cur_mag};
          opd_q   <= {32'd0, cur_mag};
          op_q    <= OP_MUL;
          cnt_q   <= tbec_pkg::LONG_STEPS;
          next_q  <= S_ACCP;
          state_q <= S_RUN;
        end
        S_ACCP: begin
          r2_q <= r2_q + acc_q[63:0];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= S_SQRTR;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SQP;
          end
        end
        S_SQRTR: begin
          acc_q   <= {64'd0, r2_q};
          opd_q   <= '0;
          op_q    <= OP_SQRT;
          cnt_q   <= tbec_pkg::ROOT_STEPS;
          next_q  <= S_GETR;
          state_q <= S_RUN;
        end
        S_GETR: begin
          r_q <= opd_q[31:0];
          if (!step_q) begin
            r2_q    <= '0;
            state_q <= S_SQV;
          end else if (opd_q[31:0] == 32'd0) begin
            zr_q    <= 1'b1;
            state_q <= S_MULP;
          end else begin
            state_q <= S_DIVG;
          end
        end
        S_DIVG: begin
          // grav_param * 2^(2*FRAC_BITS) over r^2
          acc_q     <= {33'd0, grav_q, 64'd0} >> (64 - 2 * tbec_pkg::FRAC_BITS);
          opd_q     <= r2_q;
          div_sat_q <= (64'(grav_q) >> (64 - 2 * tbec_pkg::FRAC_BITS)) >= r2_q;
          op_q      <= OP_DIV;
          cnt_q     <= tbec_pkg::LONG_STEPS;
          next_q    <= S_GETMAG;
          state_q   <= S_RUN;
        end
        S_GETMAG: begin
          mag_q   <= quot;
          state_q <= S_MULA;
        end
        S_MULA: begin
          acc_q   <= {96'd0, cur_mag};
          opd_q   <= mag_q;
          op_q    <= OP_MUL;
          cnt_q   <= tbec_pkg::LONG_STEPS;
          next_q  <= S_DIVA;
          state_q <= S_RUN;
        end
        S_DIVA: begin
          // the product stays in place as the dividend
          opd_q     <= {32'd0, r_q};
          div_sat_q <= acc_q[127:64] >= {32'd0, r_q};
          op_q      <= OP_DIV;
          cnt_q     <= tbec_pkg::LONG_STEPS;
          next_q    <= S_MULH;
          state_q   <= S_RUN;
        end
        S_MULH: begin
          acc_q   <= {64'd0, quot};
          opd_q   <= {33'd0, step_size_q};
          op_q    <= OP_MUL;
          cnt_q   <= tbec_pkg::LONG_STEPS;
          next_q  <= S_VUPD;
          state_q <= S_RUN;
        end
        S_VUPD: begin
          vel_q[idx_q] <= vupd[31:0];
          ovf_q        <= ovf_q | vupd[32];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= S_MULP;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_MULA;
          end
        end
        S_MULP: begin
          acc_q   <= {96'd0, mag32(vel_q[idx_q])};
          opd_q   <= {33'd0, step_size_q};
          op_q    <= OP_MUL;
          cnt_q   <= tbec_pkg::LONG_STEPS;
          next_q  <= S_PUPD;
          state_q <= S_RUN;
        end
        S_PUPD: begin
          pos_q[idx_q] <= pupd[31:0];
          ovf_q        <= ovf_q | pupd[32];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            r2_q    <= '0;
            state_q <= S_SQV;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_MULP;
          end
        end
        S_SQV: begin
          acc_q   <= {96'd0, mag32(vel_q[idx_q])};
          opd_q   <= {32'd0, mag32(vel_q[idx_q])};
          op_q    <= OP_MUL;
          cnt_q   <= tbec_pkg::LONG_STEPS;
          next_q  <= S_ACCV;
          state_q <= S_RUN;
        end
        S_ACCV: begin
          r2_q <= r2_q + acc_q[63:0];
          if (idx_q == 2'd2) begin
            idx_q   <= '0;
            state_q <= S_SQRTS;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SQV;
          end
        end
        S_SQRTS: begin
          acc_q   <= {64'd0, r2_q};
          opd_q   <= '0;
          op_q    <= OP_SQRT;
          cnt_q   <= tbec_pkg::ROOT_STEPS;
          next_q  <= S_GETS;
          state_q <= S_RUN;
        end
        S_GETS: begin
          spd_q   <= opd_q[31:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {fin_status, spd_c[30:0], rad_c[30:0],
                          vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TBEC_ASSERT(a_run_count, (state_q == S_RUN) |-> (cnt_q != '0), "serial unit ran past its count")
  `TBEC_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tdata[255:254] != tbec_pkg::STATUS_BAD), "bad status code")
  `TBEC_ASSERT(a_zero_radius, (m_axis_tvalid && (m_axis_tdata[255:254] == tbec_pkg::STATUS_ZERO)) |-> (m_axis_tdata[222:192] == '0), "zero-radius status with nonzero radius")
  `TBEC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule
`default_nettype wire

@@ test/tb_two_body_euler_cromer_step.sv @@
// Testbench of the two-body Euler-Cromer orbit integrator.
`timescale 1ns / 1ps

module tb_two_body_euler_cromer_step;

  // Expected content of one output transaction.
  typedef struct {
    tbec_pkg::word_t                  pos[3];
    tbec_pkg::word_t                  vel[3];
    logic [tbec_pkg::CFG_BITS-1:0]    radius;
    logic [tbec_pkg::CFG_BITS-1:0]    speed;
    logic [1:0]                       status;
  } orbit_result_t;

  // Orbit predictor and store of expected results.
  class orbit_scoreboard;
    longint signed  pos[3];
    longint signed  vel[3];
    logic [63:0]    grav;
    logic [63:0]    hstep;
    bit             ovf;
    orbit_result_t  pending_q[$];
    int             mismatches;
    int             loads, steps, zero_hits, sat_hits, checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0;
        vel[i] = 0;
      end
      grav  = 64'(tbec_pkg::GRAV_RESET);
      hstep = 64'(tbec_pkg::STEP_RESET);
    endfunction

    function void write_reg(logic [tbec_pkg::CFG_IDX_BITS-1:0] idx, tbec_pkg::word_t val);
      if (idx == tbec_pkg::CFG_GRAV) grav = 64'(val[tbec_pkg::CFG_BITS-1:0]);
      else if (idx == tbec_pkg::CFG_STEP) hstep = 64'(val[tbec_pkg::CFG_BITS-1:0]);
    endfunction

    function logic [63:0] abs_of(longint signed s);
      return (s < 0) ? 64'(-s) : 64'(s);
    endfunction

    // Sum of squares, wrapping at 64 bits like the hardware accumulator.
    function logic [63:0] sum_sq(longint signed w[3]);
      logic [63:0] acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += abs_of(w[i]) * abs_of(w[i]);
      return acc;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic [63:0] div_sat(logic [127:0] n, logic [63:0] d);
      if (d == 0 || n[127:64] >= d) return '1;
      return 64'(n / 128'(d));
    endfunction

    function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      if (p[127:64+tbec_pkg::FRAC_BITS] != 0) return '1;
      return p[63+tbec_pkg::FRAC_BITS:tbec_pkg::FRAC_BITS];
    endfunction

    function longint signed add_clamp(longint signed base, logic [63:0] amt, bit neg);
      longint signed r;
      if (amt > (64'd1 << tbec_pkg::WORD_BITS)) amt = 64'd1 << tbec_pkg::WORD_BITS;
      r = neg ? base - longint'(amt) : base + longint'(amt);
      if (r > longint'(tbec_pkg::SMAX)) begin
        ovf = 1;
        return longint'(tbec_pkg::SMAX);
      end
      if (r < -longint'(tbec_pkg::SMAX) - 1) begin
        ovf = 1;
        return -longint'(tbec_pkg::SMAX) - 1;
      end
      return r;
    endfunction

    function logic [tbec_pkg::CFG_BITS-1:0] clamp_mag(logic [63:0] v);
      if (v > 64'(tbec_pkg::SMAX)) begin
        ovf = 1;
        return tbec_pkg::SMAX[tbec_pkg::CFG_BITS-1:0];
      end
      return v[tbec_pkg::CFG_BITS-1:0];
    endfunction

    // Note an accepted input transaction and queue its expected result.
    function void note_input(logic cmd, logic [tbec_pkg::IN_DATA_BITS-1:0] d);
      logic [63:0] r2, r, accel, a, dv, dp;
      bit zero_r;
      orbit_result_t e;
      ovf = 0;
      zero_r = 0;
      if (cmd == tbec_pkg::CMD_LOAD) begin
        loads++;
        for (int i = 0; i < 3; i++) begin
          pos[i] = longint'(signed'(d[tbec_pkg::WORD_BITS*i +: tbec_pkg::WORD_BITS]));
          vel[i] = longint'(signed'(d[tbec_pkg::WORD_BITS*(i+3) +: tbec_pkg::WORD_BITS]));
        end
        r = floor_sqrt(sum_sq(pos));
      end else begin
        steps++;
        r2 = sum_sq(pos);
        r = floor_sqrt(r2);
        if (r == 0) begin
          zero_r = 1;
        end else begin
          accel = div_sat(128'(grav) << (2*tbec_pkg::FRAC_BITS), r2);
          for (int i = 0; i < 3; i++) begin
            a  = div_sat(128'(accel) * 128'(abs_of(pos[i])), r);
            dv = mul_q(hstep, a);
            vel[i] = add_clamp(vel[i], dv, pos[i] >= 0);
          end
        end
        for (int i = 0; i < 3; i++) begin
          dp = mul_q(hstep, abs_of(vel[i]));
          pos[i] = add_clamp(pos[i], dp, vel[i] < 0);
        end
      end
      for (int i = 0; i < 3; i++) begin
        e.pos[i] = tbec_pkg::word_t'(pos[i]);
        e.vel[i] = tbec_pkg::word_t'(vel[i]);
      end
      e.radius = clamp_mag(r);
      e.speed  = clamp_mag(floor_sqrt(sum_sq(vel)));
      e.status = ovf ? tbec_pkg::STATUS_SAT
               : (zero_r ? tbec_pkg::STATUS_ZERO : tbec_pkg::STATUS_OK);
      if (e.status == tbec_pkg::STATUS_SAT) sat_hits++;
      if (e.status == tbec_pkg::STATUS_ZERO) zero_hits++;
      pending_q.push_back(e);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // Compare one output transaction with the oldest expectation.
    function void check_result(logic [tbec_pkg::OUT_DATA_BITS-1:0] t);
      orbit_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %h", $time, t);
        return;
      end
      e = pending_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (t[tbec_pkg::WORD_BITS*i +: tbec_pkg::WORD_BITS] !== e.pos[i])
          report($sformatf("new_pos[%0d]", i), e.pos[i],
                 t[tbec_pkg::WORD_BITS*i +: tbec_pkg::WORD_BITS]);
        if (t[tbec_pkg::WORD_BITS*(i+3) +: tbec_pkg::WORD_BITS] !== e.vel[i])
          report($sformatf("new_vel[%0d]", i), e.vel[i],
                 t[tbec_pkg::WORD_BITS*(i+3) +: tbec_pkg::WORD_BITS]);
      end
      if (t[192 +: tbec_pkg::CFG_BITS] !== e.radius)
        report("radius", e.radius, t[192 +: tbec_pkg::CFG_BITS]);
      if (t[223 +: tbec_pkg::CFG_BITS] !== e.speed)
        report("speed", e.speed, t[223 +: tbec_pkg::CFG_BITS]);
      if (t[255:254] !== e.status) report("status", e.status, t[255:254]);
    endfunction
  endclass

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 s_axis_tvalid;
  logic                                 s_axis_tready;
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  logic [tbec_pkg::IN_DATA_BITS-1:0]    s_axis_tdata;
  // command
  logic [0:0]                           s_axis_tuser;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready;
  // new pos x/y/z, new vel x/y/z, radius, speed, status
  logic [tbec_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [tbec_pkg::CFG_IDX_BITS-1:0]    cfg_index_i;
  logic [tbec_pkg::WORD_BITS-1:0]       cfg_data_i;

  orbit_scoreboard sb = new();
  bit no_gaps;  // quiet stretch: neither side idles

  two_body_euler_cromer_step DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Send one item; valid stays high from one item to the next when no gap is drawn.
  task automatic push_item(logic cmd, logic [tbec_pkg::IN_DATA_BITS-1:0] d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, d);
  endtask

  function automatic logic [tbec_pkg::IN_DATA_BITS-1:0] pack_state(
      tbec_pkg::word_t px, tbec_pkg::word_t py, tbec_pkg::word_t pz,
      tbec_pkg::word_t vx, tbec_pkg::word_t vy, tbec_pkg::word_t vz);
    return {vz, vy, vx, pz, py, px};
  endfunction

  // Hold the sender until every expected result is back, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tbec_pkg::CFG_IDX_BITS-1:0] idx, tbec_pkg::word_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Plausible orbit: position near unit distance, velocity of a few units per time.
  function automatic tbec_pkg::word_t near_word(int lo_bit, int hi_bit);
    tbec_pkg::word_t m;
    m = tbec_pkg::word_t'($urandom_range(1 << lo_bit, 1 << hi_bit));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Output side: stall at random, check every accepted result.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tbec_pkg::word_t grav_set[8], step_set[8];
    int n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tbec_pkg::CMD_LOAD;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = tbec_pkg::CFG_GRAV;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: step from reset (zero radius), extremes, a real orbit, tiny radius.
    push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, pack_state(tbec_pkg::SMAX, tbec_pkg::SMAX, tbec_pkg::SMAX,
                                             tbec_pkg::SMIN, tbec_pkg::SMIN, tbec_pkg::SMIN));
    push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, pack_state(tbec_pkg::SMIN, tbec_pkg::SMIN, tbec_pkg::SMIN,
                                             tbec_pkg::SMAX, tbec_pkg::SMAX, tbec_pkg::SMAX));
    push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, '1);
    push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, pack_state(32'h0100_0000, 0, 0, 0, 32'd105414357, 0));
    repeat (4) push_item(tbec_pkg::CMD_STEP, '1);
    push_item(tbec_pkg::CMD_LOAD,
              pack_state(0, 0, 0, 32'h0100_0000, -32'sh0200_0000, 32'd5));
    repeat (2) push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, pack_state(1, 0, 0, 0, 0, 0));
    push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD,
              pack_state(-32'sh0080_0000, 32'h0060_0000, -32'sh0010_0000,
                         32'h0300_0000, 32'h0500_0000, -32'sh0100_0000));
    repeat (3) push_item(tbec_pkg::CMD_STEP, '0);
    push_item(tbec_pkg::CMD_LOAD, '0);
    drain();

    // Register settings: defaults, extremes, masked top bit, ignored indexes.
    grav_set = '{32'(tbec_pkg::GRAV_RESET), 32'h7FFF_FFFF, 32'h0,
                 32'h8000_0000 | 32'(tbec_pkg::GRAV_RESET),
                 32'h0200_0000, 32'h3000_0000, 32'h0, 32'h7FFF_FFFF};
    step_set = '{32'(tbec_pkg::STEP_RESET), 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0100,
                 32'h0000_1000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001};
    for (int p = 0; p < 8; p++) begin
      write_reg(tbec_pkg::CFG_GRAV, grav_set[p]);
      write_reg(tbec_pkg::CFG_STEP, step_set[p]);
      write_reg(tbec_pkg::CFG_IDX_BITS'(2 + p * 31), tbec_pkg::word_t'($urandom));
      no_gaps = (p % 3 == 1);
      n = 0;
      while (n < 235) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: full-range load, sometimes followed by a step or two
          push_item(tbec_pkg::CMD_LOAD,
                    {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
          n++;
          repeat ($urandom_range(0, 2)) begin
            push_item(tbec_pkg::CMD_STEP, {6{$urandom}});
            n++;
          end
        end else begin
          push_item(tbec_pkg::CMD_LOAD, pack_state(near_word(18, 26), near_word(18, 26),
                                                   near_word(0, 24), near_word(16, 27),
                                                   near_word(16, 27), near_word(0, 24)));
          n++;
          repeat ($urandom_range(5, 30)) begin
            push_item(tbec_pkg::CMD_STEP, {6{$urandom}});
            n++;
          end
        end
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("Covered %0d loads and %0d steps in a reset phase and 8 register phases",
             sb.loads, sb.steps);
    $display("Results checked %0d, zero-radius %0d, saturated %0d, mismatches %0d",
             sb.checked, sb.zero_hits, sb.sat_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
